[rtl/plst_pkg.sv]
`default_nettype none

package plst_pkg;

  // index widths sized for the largest supported capacity
  localparam int MAX_CAPACITY = 64;
  localparam int SLOT_W = 6;
  localparam int LEN_W = 7;

  localparam logic [2:0] OP_INS_HEAD = 3'd0;
  localparam logic [2:0] OP_INS_TAIL = 3'd1;
  localparam logic [2:0] OP_INS_POS  = 3'd2;
  localparam logic [2:0] OP_DEL_HEAD = 3'd3;
  localparam logic [2:0] OP_DEL_TAIL = 3'd4;
  localparam logic [2:0] OP_DEL_POS  = 3'd5;
  localparam logic [2:0] OP_READ     = 3'd6;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_NOEFFECT = 3'd1,
    ST_FULL     = 3'd2,
    ST_ELEMENT  = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    M_HOLD = 2'd0,
    M_INS  = 2'd1,
    M_DEL  = 2'd2,
    M_ROT  = 2'd3
  } chain_mode_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  typedef struct packed {
    chain_mode_t       mode;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  len;
  } chain_ctl_t;

endpackage

`default_nettype wire

[rtl/positional_list_store.sv]
// channel   ports                                         handshake
// command   in_operation, in_value, in_position           start & !busy
// result    out_status, out_element, out_last             out_valid, one cycle
//
// a mutation shifts all cells together; the status is registered at the same edge
// read-out gives one beat per element from the head cell while the chain rotates,
// so it holds busy until the last element has been given; an empty list gives one beat
// reset (rst_n, synchronous) empties the list; cell contents are not cleared
// the receiver cannot stall: every beat is shown for exactly one cycle
`default_nettype none

module positional_list_store #(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_operation,
  input  wire logic signed [31:0] in_value,
  input  wire logic [7:0]         in_position,
  output logic                    out_valid,
  output logic [2:0]              out_status,
  output logic signed [31:0]      out_element,
  output logic                    out_last
);

  localparam int LW  = $clog2(CAPACITY + 1);
  localparam int CLW = plst_pkg::LEN_W;
  localparam int CSW = plst_pkg::SLOT_W;
  localparam logic [LW-1:0] CAP_LEN = LW'(CAPACITY);

  plst_pkg::state_t     state_r, state_nxt;
  logic [LW-1:0]        len_r, len_nxt;
  logic [LW-1:0]        rd_cnt_r, rd_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  plst_pkg::status_t    out_status_r, out_status_nxt;
  logic signed [31:0]   out_element_r, out_element_nxt;
  logic                 out_last_r, out_last_nxt;
  plst_pkg::chain_ctl_t ctl;
  logic [8:0]           slot9;
  logic [8:0]           pos9;
  logic [8:0]           len9;
  logic [LW-1:0]        tail_cnt;
  logic                 full;
  logic signed [31:0]   cell_q [CAPACITY];

  assign pos9     = {1'b0, in_position};
  assign len9     = 9'(len_r);
  assign full     = (len_r == CAP_LEN);
  assign tail_cnt = len_r - LW'(1);
  assign busy     = (state_r == plst_pkg::S_READ);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      plst_pkg::S_IDLE: begin
        if (start && in_operation == plst_pkg::OP_READ && len_r > LW'(1))
          state_nxt = plst_pkg::S_READ;
      end
      plst_pkg::S_READ: begin
        if (rd_cnt_r == tail_cnt) state_nxt = plst_pkg::S_IDLE;
      end
      default: state_nxt = plst_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl.mode        = plst_pkg::M_HOLD;
    slot9           = '0;
    len_nxt         = len_r;
    rd_cnt_nxt      = rd_cnt_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = plst_pkg::ST_NOEFFECT;
    out_element_nxt = '0;
    out_last_nxt    = 1'b1;
    unique case (state_r)
      plst_pkg::S_IDLE: begin
        if (start) begin
          out_valid_nxt = 1'b1;
          rd_cnt_nxt    = LW'(1);
          unique case (in_operation)
            plst_pkg::OP_INS_HEAD, plst_pkg::OP_INS_TAIL, plst_pkg::OP_INS_POS: begin
              if (full) begin
                out_status_nxt = plst_pkg::ST_FULL;
              end else if (in_operation == plst_pkg::OP_INS_HEAD) begin
                ctl.mode = plst_pkg::M_INS;
                slot9    = '0;
              end else if (in_operation == plst_pkg::OP_INS_TAIL) begin
                ctl.mode = plst_pkg::M_INS;
                slot9    = len9;
              end else if (pos9 >= 9'd1 && pos9 <= len9 + 9'd1) begin
                ctl.mode = plst_pkg::M_INS;
                slot9    = pos9 - 9'd1;
              end
            end
            plst_pkg::OP_DEL_HEAD: begin
              if (len_r != '0) begin
                ctl.mode = plst_pkg::M_DEL;
                slot9    = '0;
              end
            end
            plst_pkg::OP_DEL_TAIL: begin
              if (len_r != '0) begin
                ctl.mode = plst_pkg::M_DEL;
                slot9    = len9 - 9'd1;
              end
            end
            plst_pkg::OP_DEL_POS: begin
              if (pos9 >= 9'd1 && pos9 <= len9) begin
                ctl.mode = plst_pkg::M_DEL;
                slot9    = pos9 - 9'd1;
              end
            end
            plst_pkg::OP_READ: begin
              if (len_r == '0) begin
                out_status_nxt = plst_pkg::ST_EMPTY;
              end else begin
                // first beat straight from the head cell
                ctl.mode        = plst_pkg::M_ROT;
                out_status_nxt  = plst_pkg::ST_ELEMENT;
                out_element_nxt = cell_q[0];
                out_last_nxt    = (len_r == LW'(1));
              end
            end
            default: ;
          endcase
          if (ctl.mode == plst_pkg::M_INS) begin
            len_nxt        = len_r + LW'(1);
            out_status_nxt = plst_pkg::ST_DONE;
          end else if (ctl.mode == plst_pkg::M_DEL) begin
            len_nxt        = len_r - LW'(1);
            out_status_nxt = plst_pkg::ST_DONE;
          end
        end
      end
      plst_pkg::S_READ: begin
        ctl.mode        = plst_pkg::M_ROT;
        out_valid_nxt   = 1'b1;
        out_status_nxt  = plst_pkg::ST_ELEMENT;
        out_element_nxt = cell_q[0];
        out_last_nxt    = (rd_cnt_r == tail_cnt);
        rd_cnt_nxt      = rd_cnt_r + LW'(1);
      end
      default: ;
    endcase
    ctl.slot = CSW'(slot9);
    ctl.len  = CLW'(len_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plst_pkg::S_IDLE;
      len_r       <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] left_d;
    logic signed [31:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = in_value;
    end else begin : g_mid
      assign left_d = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_q[i];
    end else begin : g_inner
      assign right_d = cell_q[i+1];
    end

    plst_cell #(
      .IDX(i)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .left_d (left_d),
      .right_d(right_d),
      .head_d (cell_q[0]),
      .new_d  (in_value),
      .data_r (cell_q[i])
    );
  end

endmodule

`default_nettype wire

[rtl/plst_cell.sv]
`default_nettype none

module plst_cell #(
  parameter int IDX = 0
) (
  input  wire logic                 clk,
  input  wire plst_pkg::chain_ctl_t ctl,
  input  wire logic signed [31:0]   left_d,
  input  wire logic signed [31:0]   right_d,
  input  wire logic signed [31:0]   head_d,
  input  wire logic signed [31:0]   new_d,
  output logic signed [31:0]        data_r
);

  localparam int LW = plst_pkg::LEN_W;
  localparam logic [LW-1:0] MY_IDX = LW'(IDX);

  logic signed [31:0] data_nxt;
  logic [LW-1:0]      slot_ext;
  logic [LW-1:0]      tail_idx;

  assign slot_ext = LW'(ctl.slot);
  assign tail_idx = ctl.len - LW'(1);

  always_comb begin
    data_nxt = data_r;
    unique case (ctl.mode)
      plst_pkg::M_HOLD: data_nxt = data_r;
      plst_pkg::M_INS: begin
        if (MY_IDX == slot_ext) data_nxt = new_d;
        else if (MY_IDX > slot_ext) data_nxt = left_d;
      end
      plst_pkg::M_DEL: begin
        if (MY_IDX >= slot_ext) data_nxt = right_d;
      end
      plst_pkg::M_ROT: begin
        // head wraps around to the tail slot
        if (MY_IDX == tail_idx) data_nxt = head_d;
        else data_nxt = right_d;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire
